[hw/rtl/sfa_pkg.sv]
package sfa_pkg;

  localparam int unsigned DefMaxSegments = 16;
  localparam int unsigned DefAddrBits = 16;
  localparam int unsigned IdBits = 5;
  localparam int unsigned SizeBits = 17;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_FIT = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd4;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [0:0] REG_FIT_POLICY = 1'd0;
  localparam logic [0:0] REG_TOTAL_SIZE = 1'd1;

  typedef struct packed {
    logic        op;
    logic [16:0] request_size;
    logic [4:0]  release_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  granted_id;
    logic [15:0] granted_address;
    logic [16:0] used_bytes;
    logic [16:0] free_bytes;
    logic [4:0]  free_fragments;
  } rsp_t;

  // Command broadcast from the sequencer to every cell.
  localparam logic [2:0] CMD_HOLD = 3'd0;
  localparam logic [2:0] CMD_INIT = 3'd1;
  localparam logic [2:0] CMD_SPLIT = 3'd2;   // grab at pick, insert remainder after it
  localparam logic [2:0] CMD_TAKE = 3'd3;    // exact fit: mark pick used
  localparam logic [2:0] CMD_RELEASE = 3'd4; // free owner id, renumber higher ids
  localparam logic [2:0] CMD_MERGE = 3'd5;   // fold entry pick+1 into pick, shift up
  localparam logic [2:0] CMD_ROTATE = 3'd6;  // circular shift toward index 0

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  pick;
    logic [16:0] size;
    logic [4:0]  id;
  } cell_ctl_t;

endpackage

[hw/rtl/segment_fit_allocator.sv]
// Segment-fit allocator: keeps an address-ordered table of up to MAX_SEGMENTS
// segments covering a managed memory of total_size bytes.
// Channels: req (req_valid/req_ready/req) carries one allocate or free
// transaction; rsp (rsp_valid/rsp_ready/rsp) returns exactly one result per
// request with status, granted id/address and used/free/fragment totals.
// Configuration: cfg_we/cfg_index/cfg_data; index 0 fit policy, index 1 total
// size (reinitializes the table). Write only while idle.
// Timing: one request at a time. A request walks the row of cells once to
// find a fit (one segment per cycle, rotating the row), then runs its split,
// take or release step, then (for a free) one merge pass, then sweeps the
// row once more for totals.
// Reset: table holds one free segment [0, 65536), policy first fit, id 1.
// Stall: the result sits in an output register until rsp_ready; no new
// request is taken until it has been delivered.
module segment_fit_allocator
  import sfa_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = DefMaxSegments,
  parameter int unsigned ADDR_BITS = DefAddrBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp
);

  localparam int unsigned CntBits = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IdxBits = $clog2(MAX_SEGMENTS);
  localparam logic [ADDR_BITS:0] MemLimit = (ADDR_BITS+1)'(1) << ADDR_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_SUM = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state;
  logic [1:0] fit_policy;

  logic [ADDR_BITS-1:0] c_start [MAX_SEGMENTS];
  logic [ADDR_BITS:0]   c_len   [MAX_SEGMENTS];
  logic                 c_free  [MAX_SEGMENTS];
  logic [4:0]           c_owner [MAX_SEGMENTS];

  cell_ctl_t ctl;
  logic [ADDR_BITS:0] init_len;

  logic [CntBits-1:0] seg_count;
  logic [4:0] next_id;
  logic [CntBits-1:0] step;     // cycles of the current sweep
  logic [7:0] pos;      // table index now sitting at cell 0
  req_t cur;
  logic found;
  logic [7:0] pick;
  logic [ADDR_BITS:0] best;
  logic [7:0] mi;       // merge cursor
  logic [ADDR_BITS:0] used_acc, free_acc;
  logic [4:0] frag_acc;
  logic [2:0] status;
  logic [4:0] gid;
  logic [ADDR_BITS-1:0] gaddr;

  // clamp the configured size
  logic [16:0] cfg_sz;
  always_comb begin
    cfg_sz = (cfg_data == '0) ? 17'd1 : cfg_data;
    if (ADDR_BITS < 17 && 18'(cfg_sz) > 18'(MemLimit))
      init_len = MemLimit;
    else
      init_len = (ADDR_BITS+1)'(cfg_sz);
  end

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      localparam int unsigned Pv = (g == 0) ? 0 : g - 1;
      localparam int unsigned Nx = (g == MAX_SEGMENTS - 1) ? g : g + 1;
      sfa_cell #(.ADDR_BITS(ADDR_BITS), .IDX(g)) u_cell (
        .clk, .rst, .ctl,
        .init_len   (rst ? MemLimit : init_len),
        .prev_start (c_start[Pv]), .prev_len (c_len[Pv]),
        .prev_free  (c_free[Pv]),  .prev_owner (c_owner[Pv]),
        .next_start (c_start[Nx]), .next_len (c_len[Nx]),
        .next_free  (c_free[Nx]),  .next_owner (c_owner[Nx]),
        .wrap_start (c_start[0]),  .wrap_len (c_len[0]),
        .wrap_free  (c_free[0]),   .wrap_owner (c_owner[0]),
        .is_last    (8'(g) == 8'(seg_count) - 8'd1),
        .seg_start  (c_start[g]),  .seg_len (c_len[g]),
        .seg_free   (c_free[g]),   .seg_owner (c_owner[g])
      );
    end
  endgenerate

  assign req_ready = (state == S_IDLE) && !rst;

  logic fits;
  assign fits = c_free[0] && c_len[0] >= (ADDR_BITS+1)'(cur.request_size);

  always_comb begin
    ctl = '0;
    ctl.cmd = CMD_HOLD;
    ctl.size = cur.request_size;
    ctl.pick = pick;
    ctl.id = next_id;
    if (cfg_we && cfg_index == REG_TOTAL_SIZE) begin
      ctl.cmd = CMD_INIT;
    end else begin
      case (state)
        S_SCAN: if (step < seg_count) ctl.cmd = CMD_ROTATE;
        S_ACT: begin
          if (cur.op == OP_FREE) begin
            if (found) begin
              ctl.cmd = CMD_RELEASE;
              ctl.id = cur.release_id;
            end
          end else if (found && status == ST_OK) begin
            ctl.cmd = (c_len[pick[IdxBits-1:0]] > (ADDR_BITS+1)'(cur.request_size)) ?
                      CMD_SPLIT : CMD_TAKE;
          end
        end
        S_MERGE: begin
          ctl.pick = mi;
          if (CntBits'(mi) + CntBits'(1) < seg_count && c_free[IdxBits'(mi)] &&
              c_free[IdxBits'(mi + 8'd1)])
            ctl.cmd = CMD_MERGE;
        end
        S_SUM: if (step < seg_count) ctl.cmd = CMD_ROTATE;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fit_policy <= POL_FIRST;
      seg_count <= CntBits'(1);
      next_id <= 5'd1;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FIT_POLICY) begin
          fit_policy <= cfg_data[1:0];
        end else begin
          seg_count <= CntBits'(1);
          next_id <= 5'd1;
        end
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            found <= 1'b0;
            pick <= '0;
            best <= '0;
            step <= '0;
            pos <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // cell 0 holds entry pos; row returns to order after one full rotation
          if (step < seg_count) begin
            if (cur.op == OP_FREE) begin
              if (!found && !c_free[0] && c_owner[0] == cur.release_id) begin
                found <= 1'b1;
                pick <= pos;
              end
            end else if (fits) begin
              case (fit_policy)
                POL_FIRST: if (!found) begin
                  found <= 1'b1; pick <= pos;
                end
                POL_BEST: if (!found || c_len[0] < best) begin
                  found <= 1'b1; pick <= pos; best <= c_len[0];
                end
                POL_WORST: if (!found || c_len[0] > best) begin
                  found <= 1'b1; pick <= pos; best <= c_len[0];
                end
                default: begin
                end
              endcase
            end
            step <= step + CntBits'(1);
            pos <= pos + 8'd1;
          end else begin
            if (cur.op == OP_FREE)
              status <= found ? ST_OK : ST_NOT_FOUND;
            else if (cur.request_size == '0)
              status <= ST_ZERO_SIZE;
            else if (!found)
              status <= ST_NO_FIT;
            else if (c_len[pick[IdxBits-1:0]] > (ADDR_BITS+1)'(cur.request_size) &&
                     32'(seg_count) >= MAX_SEGMENTS)
              status <= ST_TABLE_FULL;
            else
              status <= ST_OK;
            state <= S_ACT;
          end
        end
        S_ACT: begin
          gid <= '0;
          gaddr <= '0;
          if (cur.op == OP_ALLOC && found && status == ST_OK) begin
            gid <= next_id;
            gaddr <= c_start[pick[IdxBits-1:0]];
            next_id <= next_id + 5'd1;
            if (c_len[pick[IdxBits-1:0]] > (ADDR_BITS+1)'(cur.request_size))
              seg_count <= seg_count + CntBits'(1);
          end
          if (cur.op == OP_FREE && found && next_id > 5'd1)
            next_id <= next_id - 5'd1;
          mi <= '0;
          state <= (cur.op == OP_FREE && found) ? S_MERGE : S_SUM;
          step <= '0;
          used_acc <= '0;
          free_acc <= '0;
          frag_acc <= '0;
        end
        S_MERGE: begin
          if (ctl.cmd == CMD_MERGE)
            seg_count <= seg_count - CntBits'(1);
          else if (CntBits'(mi) + CntBits'(1) < seg_count)
            mi <= mi + 8'd1;
          else
            state <= S_SUM;
        end
        S_SUM: begin
          if (step < seg_count) begin
            if (c_free[0]) begin
              free_acc <= free_acc + c_len[0];
              frag_acc <= frag_acc + 5'd1;
            end else begin
              used_acc <= used_acc + c_len[0];
            end
            step <= step + CntBits'(1);
          end else begin
            rsp.status <= status;
            rsp.granted_id <= gid;
            rsp.granted_address <= 16'(gaddr);
            rsp.used_bytes <= 17'(used_acc);
            rsp.free_bytes <= 17'(free_acc);
            rsp.free_fragments <= frag_acc;
            rsp_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/sfa_cell.sv]
module sfa_cell
  import sfa_pkg::*;
#(
  parameter int unsigned ADDR_BITS = DefAddrBits,
  parameter int unsigned IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctl_t            ctl,
  input  logic [ADDR_BITS:0]   init_len,
  // neighbor below (index-1) and above (index+1)
  input  logic [ADDR_BITS-1:0] prev_start,
  input  logic [ADDR_BITS:0]   prev_len,
  input  logic                 prev_free,
  input  logic [4:0]           prev_owner,
  input  logic [ADDR_BITS-1:0] next_start,
  input  logic [ADDR_BITS:0]   next_len,
  input  logic                 next_free,
  input  logic [4:0]           next_owner,
  input  logic [ADDR_BITS-1:0] wrap_start,
  input  logic [ADDR_BITS:0]   wrap_len,
  input  logic                 wrap_free,
  input  logic [4:0]           wrap_owner,
  input  logic                 is_last,
  output logic [ADDR_BITS-1:0] seg_start,
  output logic [ADDR_BITS:0]   seg_len,
  output logic                 seg_free,
  output logic [4:0]           seg_owner
);

  logic [7:0] me;
  assign me = 8'(IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_free <= (IDX == 0);
      seg_owner <= '0;
      seg_start <= '0;
      seg_len <= init_len;
    end else begin
      case (ctl.cmd)
        CMD_INIT: begin
          seg_free <= (IDX == 0);
          seg_owner <= '0;
          seg_start <= '0;
          seg_len <= init_len;
        end
        CMD_SPLIT: begin
          if (me == ctl.pick) begin
            seg_free <= 1'b0;
            seg_owner <= ctl.id;
            seg_len <= (ADDR_BITS+1)'(ctl.size);
          end else if (me == ctl.pick + 8'd1) begin
            seg_free <= 1'b1;
            seg_owner <= '0;
            seg_start <= prev_start + ADDR_BITS'(ctl.size);
            seg_len <= prev_len - (ADDR_BITS+1)'(ctl.size);
          end else if (me > ctl.pick + 8'd1) begin
            seg_start <= prev_start;
            seg_len <= prev_len;
            seg_free <= prev_free;
            seg_owner <= prev_owner;
          end
        end
        CMD_TAKE: begin
          if (me == ctl.pick) begin
            seg_free <= 1'b0;
            seg_owner <= ctl.id;
          end
        end
        CMD_RELEASE: begin
          if (!seg_free && seg_owner == ctl.id) begin
            seg_free <= 1'b1;
            seg_owner <= '0;
          end else if (!seg_free && seg_owner > ctl.id) begin
            seg_owner <= seg_owner - 5'd1;
          end
        end
        CMD_MERGE: begin
          if (me == ctl.pick) begin
            seg_len <= seg_len + next_len;
          end else if (me > ctl.pick) begin
            seg_start <= next_start;
            seg_len <= next_len;
            seg_free <= next_free;
            seg_owner <= next_owner;
          end
        end
        CMD_ROTATE: begin
          if (is_last) begin
            seg_start <= wrap_start;
            seg_len <= wrap_len;
            seg_free <= wrap_free;
            seg_owner <= wrap_owner;
          end else begin
            seg_start <= next_start;
            seg_len <= next_len;
            seg_free <= next_free;
            seg_owner <= next_owner;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hw/rtl/sfa_checker.sv]
module sfa_checker
  import sfa_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_no_req_while_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("result dropped");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.granted_id == '0 && rsp.granted_address == '0)
    else $error("failed request granted something");

  a_no_rsp_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid) else $error("result too early");

endmodule

bind segment_fit_allocator sfa_checker u_sfa_checker (
  .clk, .rst, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp
);
